>>> hdl/owbm_pkg.sv
// owbm_pkg: types, codes and slot timing constants of the single-wire bus master.
// Used by every module under hdl but owbm_fifo; depends on nothing.
package owbm_pkg;

    // Queue depths (front to back, back to result port)
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH   = 2;

    // Slot timing in microseconds, standard speed
    localparam logic [8:0] T_RST_LOW     = 9'd480;
    localparam logic [8:0] T_RST_SAMPLE  = 9'd80;
    localparam logic [8:0] T_RST_WAIT    = 9'd400;
    localparam logic [8:0] T_W1_LOW      = 9'd15;
    localparam logic [8:0] T_W1_REL      = 9'd45;
    localparam logic [8:0] T_W0_LOW      = 9'd60;
    localparam logic [8:0] T_RD_LOW      = 9'd4;
    localparam logic [8:0] T_RD_SAMPLE   = 9'd8;
    localparam logic [8:0] T_RD_RECOVER  = 9'd48;
    localparam logic [8:0] T_ONE         = 9'd1;

    localparam logic [3:0] BITS_BYTE = 4'd8;
    localparam logic [3:0] BITS_ONE  = 4'd1;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_RESET = 3'd1,
        OP_WBIT  = 3'd2,
        OP_RBIT  = 3'd3,
        OP_WBYTE = 3'd4,
        OP_RBYTE = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LOW     = 3'd1,
        PH_SAMPLE  = 3'd2,
        PH_RECOVER = 3'd3,
        PH_GAP     = 3'd4
    } t_phase;

    // Item class as decided by the front end
    typedef enum logic [1:0] {
        CLS_TICK = 2'd0,
        CLS_CMD  = 2'd1,
        CLS_NOP  = 2'd2
    } t_cls;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        t_cls       kind;
        t_op        op;
        logic [7:0] data_byte;
        logic       line_level;
    } t_cls_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       sampled_bit;
    } t_result;

    // Length of the low phase of a slot
    function automatic logic [8:0] low_time(input t_op kind, input logic [7:0] shift);
        if (kind == OP_RESET) begin
            return T_RST_LOW;
        end else if (kind == OP_RBIT || kind == OP_RBYTE) begin
            return T_RD_LOW;
        end else if (shift[0]) begin
            return T_W1_LOW;
        end
        return T_W0_LOW;
    endfunction

endpackage

>>> hdl/one_wire_bus_master_core.sv
// one_wire_bus_master_core: standard-speed single-wire bus master, top level.
// Depends on owbm_pkg, owbm_front, owbm_fifo, owbm_back.
//
//  channel   handshake        payload            direction
//  -------   --------------   ----------------   ---------
//  item in   push / full      i_item  (t_item)   in
//  result    pop  / empty     o_result (t_result) out
//
// Cycles: one item per clock sustained, in and out, while pop is held high.
// An item taken into the front queue is stepped by the sequencer once the
// result queue has room; its result is then on o_result (both queues read
// through), from where it can be popped.
// Each sequencer step handles one tick against the slot timer, or one command or no-op.
// Reset: synchronous, active low; both queues empty, bus released, idle.
// Stalls: with pop low the result queue fills, the sequencer holds, the
// front queue fills and full rises; a stall drops no items.
module one_wire_bus_master_core #(
    parameter int QUEUE_DEPTH = owbm_pkg::QUEUE_DEPTH,
    parameter int OUT_DEPTH   = owbm_pkg::OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  owbm_pkg::t_item   i_item,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output owbm_pkg::t_result o_result
);
    import owbm_pkg::*;

    // front to queue
    logic      w_q_push;
    logic      w_q_full;
    t_cls_item w_q_in;

    // queue to sequencer
    logic      w_q_empty;
    logic      w_q_take;
    t_cls_item w_q_out;

    // sequencer to result queue
    logic      w_out_push;
    logic      w_out_full;
    t_result   w_res;

    owbm_front u_front (
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_item (w_q_in)
    );

    // decoupling queue between classification and the slot sequencer
    owbm_fifo #(
        .WIDTH ($bits(t_cls_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_take),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    owbm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_q_empty),
        .i_item     (w_q_out),
        .o_take     (w_q_take),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_result   (w_res)
    );

    // result queue: parts the sequencer from the consumer
    owbm_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

>>> hdl/owbm_fifo.sv
// owbm_fifo: small register queue with push/full and pop/empty sides.
// Generic width and depth; no package dependency.
module owbm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count beyond depth");

endmodule

>>> hdl/owbm_front.sv
// owbm_front: accepts input items and classifies them as tick, command or no-op.
// Depends on owbm_pkg.
module owbm_front (
    input  logic                 push,
    input  owbm_pkg::t_item      i_item,
    output logic                 full,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output owbm_pkg::t_cls_item  o_q_item
);
    import owbm_pkg::*;

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

    always_comb begin
        o_q_item.data_byte  = i_item.data_byte;
        o_q_item.line_level = i_item.line_level;
        o_q_item.op         = t_op'(i_item.opcode);
        if (i_item.opcode == OP_TICK) begin
            o_q_item.kind = CLS_TICK;
        end else if (i_item.opcode <= OP_RBYTE) begin
            o_q_item.kind = CLS_CMD;
        end else begin
            // opcodes six and seven are dropped like a command while busy
            o_q_item.kind = CLS_NOP;
            o_q_item.op   = OP_TICK;
        end
    end

endmodule

>>> hdl/owbm_back.sv
// owbm_back: slot sequencer; runs one classified item per cycle and emits its result
// while the result queue has room. Depends on owbm_pkg.
module owbm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  owbm_pkg::t_cls_item  i_item,
    output logic                 o_take,
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output owbm_pkg::t_result    o_result
);
    import owbm_pkg::*;

    t_phase     r_phase, n_phase;
    logic [8:0] r_timer, n_timer;
    t_op        r_kind,  n_kind;
    logic [7:0] r_shift, n_shift;
    logic [3:0] r_bits,  n_bits;
    logic       r_sample, n_sample;

    logic       w_step;
    logic       w_done;
    logic       w_end;
    logic       w_is_read;
    logic       w_is_write;
    logic [7:0] w_cmd_shift;
    logic [3:0] w_end_bits;

    assign w_step     = i_valid && !i_out_full;
    assign o_take     = w_step;
    assign o_out_push = w_step;
    assign w_is_read  = (r_kind == OP_RBIT) || (r_kind == OP_RBYTE);
    assign w_is_write = (r_kind == OP_WBIT) || (r_kind == OP_WBYTE);
    assign w_end_bits = r_bits - 4'd1;

    always_comb begin
        unique case (i_item.op)
            OP_WBIT:  w_cmd_shift = {7'd0, i_item.data_byte[0]};
            OP_WBYTE: w_cmd_shift = i_item.data_byte;
            default:  w_cmd_shift = 8'd0;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_kind   = r_kind;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_sample = r_sample;
        w_done   = 1'b0;
        w_end    = 1'b0;
        if (w_step) begin
            unique case (i_item.kind)
                CLS_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_timer > T_ONE) begin
                            n_timer = r_timer - T_ONE;
                        end else begin
                            unique case (r_phase)
                                PH_LOW: begin
                                    if (r_kind == OP_RESET) begin
                                        n_phase = PH_SAMPLE;
                                        n_timer = T_RST_SAMPLE;
                                    end else if (w_is_read) begin
                                        n_phase = PH_SAMPLE;
                                        n_timer = T_RD_SAMPLE;
                                    end else if (r_shift[0]) begin
                                        n_phase = PH_RECOVER;
                                        n_timer = T_W1_REL;
                                    end else begin
                                        w_end = 1'b1;
                                    end
                                end
                                PH_SAMPLE: begin
                                    n_sample = i_item.line_level;
                                    if (w_is_read) begin
                                        n_shift = {i_item.line_level, r_shift[7:1]};
                                    end
                                    n_phase = PH_RECOVER;
                                    n_timer = (r_kind == OP_RESET) ? T_RST_WAIT : T_RD_RECOVER;
                                end
                                PH_RECOVER: begin
                                    w_end = 1'b1;
                                end
                                PH_GAP: begin
                                    n_phase = PH_LOW;
                                    n_timer = low_time(r_kind, r_shift);
                                end
                                default: begin
                                    n_phase = PH_IDLE;
                                    n_timer = '0;
                                end
                            endcase
                        end
                    end
                end
                CLS_CMD: begin
                    if (r_phase == PH_IDLE) begin
                        n_kind   = i_item.op;
                        n_sample = 1'b0;
                        n_shift  = w_cmd_shift;
                        n_bits   = (i_item.op == OP_WBYTE || i_item.op == OP_RBYTE) ?
                                   BITS_BYTE : BITS_ONE;
                        n_phase  = PH_LOW;
                        n_timer  = low_time(i_item.op, w_cmd_shift);
                    end
                end
                default: begin
                end
            endcase
            // end of a slot: next bit after a released gap, or command complete
            if (w_end) begin
                if (w_is_write) begin
                    n_shift = {1'b0, r_shift[7:1]};
                end
                n_bits = w_end_bits;
                if (w_end_bits == 4'd0) begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    w_done  = 1'b1;
                end else begin
                    n_phase = PH_GAP;
                    n_timer = T_ONE;
                end
            end
        end

        o_result.drive_low   = (n_phase == PH_LOW);
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = w_done;
        o_result.read_value  = (w_done && n_kind == OP_RBYTE) ? n_shift : 8'd0;
        o_result.sampled_bit = (w_done && (n_kind == OP_RESET || n_kind == OP_RBIT ||
                                           n_kind == OP_RBYTE)) ? n_sample : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_kind   <= OP_TICK;
            r_shift  <= '0;
            r_bits   <= '0;
            r_sample <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_kind   <= n_kind;
            r_shift  <= n_shift;
            r_bits   <= n_bits;
            r_sample <= n_sample;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_done |=> r_phase == PH_IDLE)
        else $error("command completed but sequencer not idle");

    a_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_timer != 9'd0)
        else $error("slot timer zero while busy");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> (r_bits != 4'd0 && r_bits <= BITS_BYTE))
        else $error("bit count out of range while busy");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_phase) && $stable(r_timer))
        else $error("sequencer moved without taking an item");

endmodule
